// File: src/f32cr_pkg.sv
// Package: constants, codes and shared types for the cluster chain walker.
package f32cr_pkg;

  localparam int TABLE_ENTRIES = 4096;
  localparam int MAX_RUNS      = 64;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int STEP_W        = $clog2(TABLE_ENTRIES + 1);
  localparam int RUN_W         = $clog2(MAX_RUNS + 1);
  localparam int CL_W          = 28;
  localparam int SEC_W         = 41;
  localparam int PROD_W        = 40;
  localparam int OFF_W         = 36;

  localparam logic [CL_W-1:0] LINK_END_MIN = 28'hFFF_FFF8;
  localparam logic [CL_W-1:0] FIRST_DATA_CLUSTER = 28'd2;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_WALK  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_BAD   = 2'd2,
    ST_TRUNC = 2'd3
  } walk_status_t;

  typedef enum logic [1:0] {
    CFG_RESERVED   = 2'd0,
    CFG_COPIES     = 2'd1,
    CFG_TABLE_SIZE = 2'd2,
    CFG_SPC        = 2'd3
  } cfg_index_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BASE,
    S_BASE_ADD,
    S_CHECK,
    S_MAP,
    S_LAST,
    S_MERGE,
    S_LINK
  } state_t;

  typedef enum logic {
    SRC_OPEN,
    SRC_ZERO
  } emit_src_t;

  typedef struct packed {
    logic              action;
    logic [CL_W-1:0]   cluster_number;
    logic [31:0]       entry_value;
  } req_t;

  typedef struct packed {
    logic [SEC_W-1:0]  run_first_sector;
    logic [SEC_W-1:0]  run_last_sector;
    logic [1:0]        walk_status;
    logic              final_run;
  } res_t;

  typedef struct packed {
    logic         wr_table;
    logic         walk_init;
    logic         base_mul;
    logic         base_add;
    logic         check;
    logic         map;
    logic         last_calc;
    logic         run_open;
    logic         run_extend;
    logic         link_adv;
    logic         emit;
    emit_src_t    emit_src;
    walk_status_t emit_status;
    logic         emit_final;
  } dp_cmd_t;

  typedef struct packed {
    logic req_short;
    logic cur_bad;
    logic have_run;
    logic contig;
    logic runs_full;
    logic link_end;
    logic steps_full;
  } dp_stat_t;

endpackage

// File: src/f32cr_dp.sv
// Datapath: configuration, allocation table, sector mapping and run registers.
module f32cr_dp (
  input  logic                   clk,
  input  logic                   rst,
  input  f32cr_pkg::req_t        request,
  input  logic                   cfg_valid,
  input  f32cr_pkg::cfg_index_t  cfg_index,
  input  logic [31:0]            cfg_data,
  input  f32cr_pkg::dp_cmd_t     cmd,
  output f32cr_pkg::dp_stat_t    stat,
  output f32cr_pkg::res_t        result,
  output logic                   result_valid
);

  logic [f32cr_pkg::CL_W-1:0]   alloc_table [f32cr_pkg::TABLE_ENTRIES];

  logic [15:0]                  reserved_sectors;
  logic [7:0]                   table_copies;
  logic [31:0]                  table_size_sectors;
  logic [7:0]                   sectors_per_cluster;

  logic [f32cr_pkg::CL_W-1:0]   cur;
  logic [f32cr_pkg::CL_W-1:0]   rd_data;
  logic [f32cr_pkg::RUN_W-1:0]  runs;
  logic [f32cr_pkg::STEP_W-1:0] steps;
  logic [f32cr_pkg::PROD_W-1:0] prod;
  logic [f32cr_pkg::SEC_W-1:0]  base;
  logic [f32cr_pkg::OFF_W-1:0]  off;
  logic [f32cr_pkg::SEC_W-1:0]  first;
  logic [f32cr_pkg::SEC_W-1:0]  last;
  logic [f32cr_pkg::SEC_W-1:0]  open_first;
  logic [f32cr_pkg::SEC_W-1:0]  open_last;
  logic [f32cr_pkg::SEC_W-1:0]  open_last_p1;
  logic [f32cr_pkg::STEP_W-1:0] steps_p1;
  logic                         wr_in_range;

  always_ff @(posedge clk) begin
    if (rst) begin
      reserved_sectors    <= 16'd32;
      table_copies        <= 8'd2;
      table_size_sectors  <= 32'd1;
      sectors_per_cluster <= 8'd8;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        f32cr_pkg::CFG_RESERVED:   reserved_sectors    <= cfg_data[15:0];
        f32cr_pkg::CFG_COPIES:     table_copies        <= cfg_data[7:0];
        f32cr_pkg::CFG_TABLE_SIZE: table_size_sectors  <= cfg_data;
        f32cr_pkg::CFG_SPC:        sectors_per_cluster <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign wr_in_range = request.cluster_number
                       < f32cr_pkg::CL_W'(f32cr_pkg::TABLE_ENTRIES);

  always_ff @(posedge clk) begin
    if (cmd.wr_table && wr_in_range) begin
      alloc_table[request.cluster_number[f32cr_pkg::IDX_W-1:0]] <=
        request.entry_value[f32cr_pkg::CL_W-1:0];
    end
    if (cmd.check) begin
      rd_data <= alloc_table[cur[f32cr_pkg::IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      runs  <= '0;
      steps <= '0;
    end else if (cmd.walk_init) begin
      runs  <= '0;
      steps <= '0;
    end else begin
      if (cmd.run_open) begin
        runs <= f32cr_pkg::RUN_W'(runs + 1'b1);
      end
      if (cmd.link_adv) begin
        steps <= steps_p1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_init) begin
      cur        <= request.cluster_number;
      open_first <= '0;
      open_last  <= '0;
    end else begin
      if (cmd.link_adv) begin
        cur <= rd_data;
      end
      if (cmd.run_open) begin
        open_first <= first;
        open_last  <= last;
      end else if (cmd.run_extend) begin
        open_last <= last;
      end
    end
    if (cmd.base_mul) begin
      prod <= f32cr_pkg::PROD_W'(table_copies) * f32cr_pkg::PROD_W'(table_size_sectors);
    end
    if (cmd.base_add) begin
      base <= f32cr_pkg::SEC_W'(reserved_sectors) + f32cr_pkg::SEC_W'(prod);
    end
    if (cmd.check) begin
      off <= f32cr_pkg::OFF_W'(cur - f32cr_pkg::FIRST_DATA_CLUSTER)
             * f32cr_pkg::OFF_W'(sectors_per_cluster);
    end
    if (cmd.map) begin
      first <= base + f32cr_pkg::SEC_W'(off);
    end
    if (cmd.last_calc) begin
      last <= first + f32cr_pkg::SEC_W'(sectors_per_cluster) - f32cr_pkg::SEC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (cmd.emit_src == f32cr_pkg::SRC_OPEN) begin
        result.run_first_sector <= open_first;
        result.run_last_sector  <= open_last;
      end else begin
        result.run_first_sector <= '0;
        result.run_last_sector  <= '0;
      end
      result.walk_status <= cmd.emit_status;
      result.final_run   <= cmd.emit_final;
    end
  end

  assign open_last_p1 = open_last + f32cr_pkg::SEC_W'(1);
  assign steps_p1     = f32cr_pkg::STEP_W'(steps + 1'b1);

  always_comb begin
    stat.req_short  = request.cluster_number < f32cr_pkg::FIRST_DATA_CLUSTER;
    stat.cur_bad    = (cur < f32cr_pkg::FIRST_DATA_CLUSTER)
                      || (cur >= f32cr_pkg::CL_W'(f32cr_pkg::TABLE_ENTRIES));
    stat.have_run   = runs != '0;
    stat.contig     = first == open_last_p1;
    stat.runs_full  = runs >= f32cr_pkg::RUN_W'(f32cr_pkg::MAX_RUNS);
    stat.link_end   = rd_data >= f32cr_pkg::LINK_END_MIN;
    stat.steps_full = steps_p1 >= f32cr_pkg::STEP_W'(f32cr_pkg::TABLE_ENTRIES);
  end

endmodule

// File: src/f32cr_ctrl.sv
// Controller: walk sequencing state machine driving the datapath.
module f32cr_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 action,
  input  f32cr_pkg::dp_stat_t  stat,
  output f32cr_pkg::dp_cmd_t   cmd,
  output logic                 busy
);

  f32cr_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= f32cr_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = state != f32cr_pkg::S_IDLE;

  always_comb begin
    state_next      = state;
    cmd             = '0;
    cmd.emit_src    = f32cr_pkg::SRC_OPEN;
    cmd.emit_status = f32cr_pkg::ST_OK;
    unique case (state)
      f32cr_pkg::S_IDLE: begin
        if (start) begin
          if (action == f32cr_pkg::ACT_WRITE) begin
            cmd.wr_table = 1'b1;
          end else if (stat.req_short) begin
            cmd.emit        = 1'b1;
            cmd.emit_src    = f32cr_pkg::SRC_ZERO;
            cmd.emit_status = f32cr_pkg::ST_EMPTY;
            cmd.emit_final  = 1'b1;
          end else begin
            cmd.walk_init = 1'b1;
            state_next    = f32cr_pkg::S_BASE;
          end
        end
      end
      f32cr_pkg::S_BASE: begin
        cmd.base_mul = 1'b1;
        state_next   = f32cr_pkg::S_BASE_ADD;
      end
      f32cr_pkg::S_BASE_ADD: begin
        cmd.base_add = 1'b1;
        state_next   = f32cr_pkg::S_CHECK;
      end
      f32cr_pkg::S_CHECK: begin
        if (stat.cur_bad) begin
          cmd.emit        = 1'b1;
          cmd.emit_src    = stat.have_run ? f32cr_pkg::SRC_OPEN : f32cr_pkg::SRC_ZERO;
          cmd.emit_status = f32cr_pkg::ST_BAD;
          cmd.emit_final  = 1'b1;
          state_next      = f32cr_pkg::S_IDLE;
        end else begin
          cmd.check  = 1'b1;
          state_next = f32cr_pkg::S_MAP;
        end
      end
      f32cr_pkg::S_MAP: begin
        cmd.map    = 1'b1;
        state_next = f32cr_pkg::S_LAST;
      end
      f32cr_pkg::S_LAST: begin
        cmd.last_calc = 1'b1;
        state_next    = f32cr_pkg::S_MERGE;
      end
      f32cr_pkg::S_MERGE: begin
        state_next = f32cr_pkg::S_LINK;
        if (!stat.have_run) begin
          cmd.run_open = 1'b1;
        end else if (stat.contig) begin
          cmd.run_extend = 1'b1;
        end else if (stat.runs_full) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = f32cr_pkg::ST_TRUNC;
          cmd.emit_final  = 1'b1;
          state_next      = f32cr_pkg::S_IDLE;
        end else begin
          cmd.emit     = 1'b1;
          cmd.run_open = 1'b1;
        end
      end
      f32cr_pkg::S_LINK: begin
        cmd.link_adv = 1'b1;
        if (stat.link_end) begin
          cmd.emit       = 1'b1;
          cmd.emit_final = 1'b1;
          state_next     = f32cr_pkg::S_IDLE;
        end else if (stat.steps_full) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = f32cr_pkg::ST_TRUNC;
          cmd.emit_final  = 1'b1;
          state_next      = f32cr_pkg::S_IDLE;
        end else begin
          state_next = f32cr_pkg::S_CHECK;
        end
      end
      default: begin
        state_next = f32cr_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// File: src/fat32_chain_to_sector_runs_top.sv
// Top level: FAT32 cluster chain walker reporting contiguous sector runs.
//
//   channel   handshake                beat
//   request   start in, busy out       action, cluster number, entry value
//   result    result_valid out         first/last sector, status, final mark
//   config    cfg_valid in, cfg_ready  cfg_index, cfg_data
//
// A table write or an empty-chain walk is taken while idle; busy stays low.
// A walk holds busy while it forms the table base (multiply, then add), then runs check,
// map, end sector, merge and link per cluster; a bad link ends it at a check, and the
// run limit cuts it at merge.
// Each result beat is registered and appears in the cycle after the step that makes it.
// Reset (rst, synchronous) restores the register defaults; the table is unset.
// Each result is shown for one cycle; the receiver cannot stall it.
module fat32_chain_to_sector_runs_top (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  f32cr_pkg::req_t        request,
  output f32cr_pkg::res_t        result,
  output logic                   result_valid,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  f32cr_pkg::cfg_index_t  cfg_index,
  input  logic [31:0]            cfg_data
);

  f32cr_pkg::dp_cmd_t  cmd;
  f32cr_pkg::dp_stat_t stat;

  assign cfg_ready = 1'b1;

  f32cr_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .action (request.action),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy)
  );

  f32cr_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .request      (request),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .stat         (stat),
    .result       (result),
    .result_valid (result_valid)
  );

  a_final_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.final_run |-> !busy)
    else $error("final beat while walk still active");

  a_idle_final: assert property (@(posedge clk) disable iff (rst)
    result_valid && !busy |-> result.final_run)
    else $error("non-final beat after walk ended");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (request.action == f32cr_pkg::ACT_WALK)
      && (request.cluster_number < f32cr_pkg::FIRST_DATA_CLUSTER)
    |=> result_valid && (result.walk_status == f32cr_pkg::ST_EMPTY) && !busy)
    else $error("empty chain not reported");

endmodule

// File: tb/tb.sv
// Testbench for the cluster chain walker: loads tables, walks chains, checks every run beat.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import f32cr_pkg::*;

  localparam int WATCHDOG = 100000;
  localparam int SETTLE   = 12;

  logic       clk;
  logic       rst       = 1'b1;
  logic       start     = 1'b0;
  logic       busy;
  req_t       request   = '0;
  res_t       result;
  logic       result_valid;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  cfg_index_t cfg_index = CFG_RESERVED;
  logic [31:0] cfg_data = '0;

  req_t req_pend[$];
  res_t runs_due[$];

  logic [CL_W-1:0] fat_copy [TABLE_ENTRIES];
  logic [CL_W-1:0] gen_fat  [TABLE_ENTRIES];
  bit              gen_set  [TABLE_ENTRIES];

  logic [15:0] vol_reserved = 16'd32;
  logic [7:0]  vol_copies   = 8'd2;
  logic [31:0] vol_tsize    = 32'd1;
  logic [7:0]  vol_spc      = 8'd8;

  int fails       = 0;
  int idle_cycles = 0;
  int queued      = 0;
  int ph;
  bit gaps_on     = 1'b1;
  bit req_took    = 1'b0;

  fat32_chain_to_sector_runs_top dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .request      (request),
    .result       (result),
    .result_valid (result_valid),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [SEC_W-1:0] cluster_sector(logic [CL_W-1:0] c);
    logic [SEC_W-1:0] base, span, idx;
    base = SEC_W'(vol_tsize);
    span = SEC_W'(vol_copies);
    base = base * span + SEC_W'(vol_reserved);
    idx  = SEC_W'(c);
    span = SEC_W'(vol_spc);
    return base + (idx - 41'd2) * span;
  endfunction

  function automatic void add_run(logic [SEC_W-1:0] f, logic [SEC_W-1:0] l,
                                  walk_status_t st, logic fin);
    res_t r;
    r.run_first_sector = f;
    r.run_last_sector  = l;
    r.walk_status      = st;
    r.final_run        = fin;
    runs_due.insert(runs_due.size(), r);
  endfunction

  function automatic void walk_chain_runs(logic [CL_W-1:0] head);
    logic [CL_W-1:0]  cur, link;
    logic [SEC_W-1:0] first, last, run_first, run_last;
    int runs, steps;
    if (head < FIRST_DATA_CLUSTER) begin
      add_run('0, '0, ST_EMPTY, 1'b1);
      return;
    end
    cur       = head;
    runs      = 0;
    steps     = 0;
    run_first = '0;
    run_last  = '0;
    forever begin
      if (cur < FIRST_DATA_CLUSTER || cur >= CL_W'(TABLE_ENTRIES)) begin
        add_run(run_first, run_last, ST_BAD, 1'b1);
        return;
      end
      first = cluster_sector(cur);
      last  = first + SEC_W'(vol_spc) - 41'd1;
      if (runs == 0) begin
        run_first = first;
        run_last  = last;
        runs      = 1;
      end else if (first == run_last + 41'd1) begin
        run_last = last;
      end else if (runs >= MAX_RUNS) begin
        add_run(run_first, run_last, ST_TRUNC, 1'b1);
        return;
      end else begin
        add_run(run_first, run_last, ST_OK, 1'b0);
        run_first = first;
        run_last  = last;
        runs++;
      end
      link = fat_copy[cur[IDX_W-1:0]];
      steps++;
      if (link >= LINK_END_MIN) begin
        add_run(run_first, run_last, ST_OK, 1'b1);
        return;
      end
      if (steps >= TABLE_ENTRIES) begin
        add_run(run_first, run_last, ST_TRUNC, 1'b1);
        return;
      end
      cur = link;
    end
  endfunction

  // a walk may only touch entries already loaded
  function automatic bit chain_readable(logic [CL_W-1:0] head);
    logic [CL_W-1:0] c;
    int n;
    c = head;
    for (n = 0; n < TABLE_ENTRIES; n++) begin
      if (c < FIRST_DATA_CLUSTER || c >= CL_W'(TABLE_ENTRIES)) return 1'b1;
      if (!gen_set[c[IDX_W-1:0]]) return 1'b0;
      if (gen_fat[c[IDX_W-1:0]] >= LINK_END_MIN) return 1'b1;
      c = gen_fat[c[IDX_W-1:0]];
    end
    return 1'b1;
  endfunction

  task automatic queue_item(logic act, logic [CL_W-1:0] cl, logic [31:0] ev);
    req_t r;
    r.action         = act;
    r.cluster_number = cl;
    r.entry_value    = ev;
    req_pend.insert(req_pend.size(), r);
    if (act == ACT_WALK) begin
      queued++;
    end else if (cl < CL_W'(TABLE_ENTRIES)) begin
      gen_fat[cl[IDX_W-1:0]] = ev[CL_W-1:0];
      gen_set[cl[IDX_W-1:0]] = 1'b1;
      queued++;
    end
  endtask

  task automatic queue_walk(logic [CL_W-1:0] head);
    if (chain_readable(head)) queue_item(ACT_WALK, head, $urandom);
  endtask

  function automatic logic [31:0] link_word(logic [CL_W-1:0] link);
    return ($urandom & 32'hF000_0000) | {4'd0, link};
  endfunction

  task automatic queue_chain(int len);
    logic [CL_W-1:0] cl[$];
    logic [CL_W-1:0] cur, nxt, tail;
    int k, pick;
    cl.insert(0, CL_W'($urandom_range(TABLE_ENTRIES - 1, 2)));
    for (k = 1; k < len; k++) begin
      cur = cl[cl.size() - 1];
      if ($urandom_range(99) < 70 && cur < CL_W'(TABLE_ENTRIES - 1)) nxt = cur + 28'd1;
      else nxt = CL_W'($urandom_range(TABLE_ENTRIES - 1, 2));
      cl.insert(cl.size(), nxt);
    end
    for (k = 0; k < len - 1; k++) queue_item(ACT_WRITE, cl[k], link_word(cl[k + 1]));
    pick = $urandom_range(99);
    if (pick < 80) tail = LINK_END_MIN | CL_W'($urandom_range(7));
    else if (pick < 88) tail = cl[0];
    else begin
      case ($urandom_range(3))
        0: tail = '0;
        1: tail = 28'd1;
        2: tail = LINK_END_MIN - 28'd1;
        default: tail = CL_W'($urandom_range(32'h0FFF_FFF7, TABLE_ENTRIES));
      endcase
    end
    queue_item(ACT_WRITE, cl[len - 1], link_word(tail));
    queue_walk(cl[0]);
    if ($urandom_range(99) < 20) queue_walk(cl[$urandom_range(len - 1)]);
  endtask

  task automatic queue_noise();
    case ($urandom_range(4))
      0: queue_item(ACT_WRITE, CL_W'($urandom_range(32'h0FFF_FFFF, TABLE_ENTRIES)),
                    $urandom);
      1: queue_item(ACT_WRITE, CL_W'($urandom_range(TABLE_ENTRIES - 1)), $urandom);
      2: queue_walk(CL_W'($urandom_range(1)));
      3: queue_walk(CL_W'($urandom_range(32'h0FFF_FFFF, TABLE_ENTRIES)));
      default: queue_walk(CL_W'($urandom_range(TABLE_ENTRIES - 1, 2)));
    endcase
  endtask

  task automatic queue_random(int goal);
    int target;
    target = queued + goal;
    while (queued < target) begin
      if ($urandom_range(99) < 15) queue_noise();
      else if ($urandom_range(99) < 10) queue_chain($urandom_range(40, 16));
      else queue_chain($urandom_range(12, 1));
    end
  endtask

  // one loop of 64 contiguous clusters, walked until the step limit cuts it
  task automatic queue_long_loop();
    int k;
    for (k = 2; k <= 65; k++) begin
      queue_item(ACT_WRITE, CL_W'(k), link_word(CL_W'((k == 65) ? 2 : k + 1)));
    end
    queue_walk(28'd2);
  endtask

  task automatic write_cfg(cfg_index_t idx, logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_volume(logic [15:0] rsv, logic [7:0] cps, logic [31:0] tsz,
                            logic [7:0] spc);
    write_cfg(CFG_RESERVED, {16'd0, rsv});
    write_cfg(CFG_COPIES, {24'd0, cps});
    write_cfg(CFG_TABLE_SIZE, tsz);
    write_cfg(CFG_SPC, {24'd0, spc});
  endtask

  task automatic drain();
    do @(posedge clk);
    while (req_pend.size() != 0 || start || runs_due.size() != 0 || busy);
    repeat (SETTLE) @(posedge clk);
  endtask

  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || req_took) begin
      if (req_pend.size() != 0 && !(gaps_on && $urandom_range(99) < 7)) begin
        request <= req_pend.pop_front();
        start   <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      req_took     <= 1'b0;
      vol_reserved = 16'd32;
      vol_copies   = 8'd2;
      vol_tsize    = 32'd1;
      vol_spc      = 8'd8;
    end else begin
      req_took <= start && !busy;
      if (result_valid) begin
        if (runs_due.size() == 0) begin
          $error("run beat with nothing pending: first %0h last %0h status %0d final %0b",
                 result.run_first_sector, result.run_last_sector,
                 result.walk_status, result.final_run);
          fails++;
        end else begin
          want = runs_due.pop_front();
          if (result.run_first_sector !== want.run_first_sector) begin
            $error("run_first_sector: expected %0h, got %0h",
                   want.run_first_sector, result.run_first_sector);
            fails++;
          end
          if (result.run_last_sector !== want.run_last_sector) begin
            $error("run_last_sector: expected %0h, got %0h",
                   want.run_last_sector, result.run_last_sector);
            fails++;
          end
          if (result.walk_status !== want.walk_status) begin
            $error("walk_status: expected %0d, got %0d", want.walk_status, result.walk_status);
            fails++;
          end
          if (result.final_run !== want.final_run) begin
            $error("final_run: expected %0b, got %0b", want.final_run, result.final_run);
            fails++;
          end
        end
      end
      if (start && !busy) begin
        if (request.action == ACT_WALK) begin
          walk_chain_runs(request.cluster_number);
        end else if (request.cluster_number < CL_W'(TABLE_ENTRIES)) begin
          fat_copy[request.cluster_number[IDX_W-1:0]] = request.entry_value[CL_W-1:0];
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_RESERVED:   vol_reserved = cfg_data[15:0];
          CFG_COPIES:     vol_copies   = cfg_data[7:0];
          CFG_TABLE_SIZE: vol_tsize    = cfg_data;
          CFG_SPC:        vol_spc      = cfg_data[7:0];
          default: ;
        endcase
      end
      if ((start && !busy) || result_valid || (cfg_valid && cfg_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG) begin
        $display("tb failed");
        $finish;
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    queue_walk(28'd0);
    queue_walk(28'd1);
    queue_walk(CL_W'(TABLE_ENTRIES));
    queue_walk(28'hFFF_FFFF);
    queue_item(ACT_WRITE, 28'hFFF_FFFF, 32'hFFFF_FFFF);
    queue_item(ACT_WRITE, 28'd0, 32'hFFFF_FFFF);
    queue_item(ACT_WRITE, 28'd2, 32'h0000_0003);
    queue_item(ACT_WRITE, 28'd3, 32'hFFFF_FFFF);
    queue_walk(28'd2);
    queue_item(ACT_WRITE, CL_W'(TABLE_ENTRIES - 1), 32'hA000_0005);
    queue_item(ACT_WRITE, 28'd5, 32'h0FFF_FFF8);
    queue_walk(CL_W'(TABLE_ENTRIES - 1));
    queue_item(ACT_WRITE, 28'd6, 32'h0000_0000);
    queue_walk(28'd6);
    queue_item(ACT_WRITE, 28'd7, 32'h0000_0001);
    queue_walk(28'd7);
    queue_item(ACT_WRITE, 28'd8, 32'h0FFF_FFF7);
    queue_walk(28'd8);
    queue_item(ACT_WRITE, 28'd9, 32'h0000_1000);
    queue_walk(28'd9);
    queue_item(ACT_WRITE, 28'd10, 32'h5000_000A);
    queue_walk(28'd10);
    drain();

    set_volume(16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 8'd128);
    queue_random(55);
    drain();

    gaps_on = 1'b0;
    set_volume(16'd0, 8'd1, 32'd1, 8'd1);
    queue_long_loop();
    queue_random(55);
    drain();

    gaps_on = 1'b1;
    for (ph = 0; ph < 3; ph++) begin
      set_volume(16'($urandom_range(16'hFFFF)), 8'($urandom_range(255, 1)),
                 $urandom_range(32'hFFFF_FFFF, 1), 8'($urandom_range(128, 1)));
      if (ph == 2) queue_long_loop();
      queue_random(55);
      drain();
    end

    if (fails == 0 && runs_due.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/f32cr_pkg.sv
src/f32cr_dp.sv
src/f32cr_ctrl.sv
src/fat32_chain_to_sector_runs_top.sv
tb/tb.sv
